>>> hw/rtl/mp2d_pkg.sv
// Shared types and constants for the 2-D max pooling block.
// Used by mp2d_ctrl, mp2d_datapath and max_pool_2d; no dependencies.
`default_nettype none
package mp2d_pkg;

  // Configuration port widths and register indexes.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_H  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_W  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_R = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_C = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_R   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_C   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COLS    = 4'd7;

  // Result status codes.
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_ZERO_STRIDE = 2'd1;
  localparam logic [1:0] ST_KERNEL_BIG  = 2'd2;

  // Largest padding per side, and width of kernel-size values (up to 31).
  localparam int PAD_MAX = 4;
  localparam int KW      = 5;
  localparam int COORD_W = 9;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // take the input request
    logic scan;    // issue one line-store read of the window
    logic load;    // load the result into the output register
  } mp2d_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic err;        // configuration error for the current request
    logic win;        // current request completes a window
    logic scan_last;  // current read is the window's last element
    logic out_free;   // output register can take a result this cycle
  } mp2d_sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/mp2d_ctrl.sv
// Controller state machine of the 2-D max pooling block.
// Depends on mp2d_pkg for the command and status structs.
`default_nettype none
module mp2d_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mp2d_pkg::mp2d_sts_t sts_i,
  output mp2d_pkg::mp2d_cmd_t cmd_o
);
  import mp2d_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.err) begin
            state_d = S_EMIT;
          end else if (sts_i.win) begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/mp2d_datapath.sv
// Datapath of the 2-D max pooling block: configuration registers, plane
// position tracking, line store, window scan and output register.
// Depends on mp2d_pkg.
`default_nettype none
module mp2d_datapath #(
  parameter int MAX_POOL    = 8,
  parameter int MAX_COLS    = 256,
  parameter int MAX_ROWS    = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mp2d_pkg::mp2d_cmd_t                 cmd_i,
  output mp2d_pkg::mp2d_sts_t                 sts_o,
  input  logic                                cfg_we_i,
  input  logic [mp2d_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mp2d_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  input  logic                                is_pad_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic signed [SAMPLE_BITS-1:0]       max_value_o,
  output logic [mp2d_pkg::COORD_W-1:0]        out_row_o,
  output logic [mp2d_pkg::COORD_W-1:0]        out_col_o,
  output logic                                last_of_plane_o,
  output logic [1:0]                          status_o
);
  import mp2d_pkg::*;

  localparam int MaxDim = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int PwRaw  = $clog2(MaxDim + 2 * PAD_MAX + 1) + 1;
  localparam int PW     = (PwRaw < 10) ? 10 : PwRaw;
  localparam int SW     = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
  localparam int Depth  = MAX_POOL * MAX_COLS;
  localparam int AW     = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int TW     = SW + KW + 1;

  localparam logic signed [SAMPLE_BITS-1:0] SampleMin =
    {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Configuration registers
  logic [3:0] ph_raw_q, pw_raw_q, sr_q, sc_q;
  logic [2:0] pr_q, pc_q;
  logic [8:0] rows_raw_q, cols_raw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_raw_q   <= 4'd2;
      pw_raw_q   <= 4'd2;
      sr_q       <= 4'd2;
      sc_q       <= 4'd2;
      pr_q       <= 3'd0;
      pc_q       <= 3'd0;
      rows_raw_q <= 9'd256;
      cols_raw_q <= 9'd256;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_POOL_H:   ph_raw_q   <= cfg_data_i[3:0];
        REG_POOL_W:   pw_raw_q   <= cfg_data_i[3:0];
        REG_STRIDE_R: sr_q       <= cfg_data_i[3:0];
        REG_STRIDE_C: sc_q       <= cfg_data_i[3:0];
        REG_PAD_R:    pr_q       <= cfg_data_i[2:0];
        REG_PAD_C:    pc_q       <= cfg_data_i[2:0];
        REG_ROWS:     rows_raw_q <= cfg_data_i;
        REG_COLS:     cols_raw_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamped geometry
  logic [KW-1:0] ph, pw;
  logic [PW-1:0] rows, cols, pr, pc, prows, pcols, phx, pwx, srx, scx;

  always_comb begin
    if (ph_raw_q == 4'd0) ph = KW'(1);
    else if (KW'(ph_raw_q) > KW'(MAX_POOL)) ph = KW'(MAX_POOL);
    else ph = KW'(ph_raw_q);
    if (pw_raw_q == 4'd0) pw = KW'(1);
    else if (KW'(pw_raw_q) > KW'(MAX_POOL)) pw = KW'(MAX_POOL);
    else pw = KW'(pw_raw_q);
    if (rows_raw_q == 9'd0) rows = PW'(1);
    else if (PW'(rows_raw_q) > PW'(MAX_ROWS)) rows = PW'(MAX_ROWS);
    else rows = PW'(rows_raw_q);
    if (cols_raw_q == 9'd0) cols = PW'(1);
    else if (PW'(cols_raw_q) > PW'(MAX_COLS)) cols = PW'(MAX_COLS);
    else cols = PW'(cols_raw_q);
  end

  assign pr    = PW'(pr_q);
  assign pc    = PW'(pc_q);
  assign prows = rows + (pr << 1);
  assign pcols = cols + (pc << 1);
  assign phx   = PW'(ph);
  assign pwx   = PW'(pw);
  assign srx   = PW'(sr_q);
  assign scx   = PW'(sc_q);

  logic zero_stride, kernel_big;
  assign zero_stride = (sr_q == 4'd0) || (sc_q == 4'd0);
  assign kernel_big  = (phx > prows) || (pwx > pcols);

  // Plane position and stride phase counters
  logic [PW-1:0] r_q, c_q, rph_q, cph_q, orow_q, ocol_q;
  logic [SW-1:0] slot_q;

  logic row_hit, col_hit, col_end, row_end, real_pos, last_win;
  assign row_hit  = (r_q + PW'(1) >= phx) && (rph_q == '0);
  assign col_hit  = (c_q + PW'(1) >= pwx) && (cph_q == '0);
  assign col_end  = (c_q + PW'(1) >= pcols);
  assign row_end  = (r_q + PW'(1) >= prows);
  assign real_pos = (r_q >= pr) && (r_q < pr + rows) && (c_q >= pc) && (c_q < pc + cols);
  assign last_win = (r_q + srx >= prows) && (c_q + scx >= pcols);

  logic [SW-1:0] slot_inc;
  assign slot_inc = ((SW+1)'(slot_q) + (SW+1)'(1) == (SW+1)'(MAX_POOL)) ? '0 : slot_q + SW'(1);

  logic step;
  assign step = cmd_i.accept && !zero_stride && !kernel_big;

  // Only a write to a listed register restarts the plane.
  logic cfg_restart;
  assign cfg_restart = cfg_we_i && (cfg_index_i <= REG_COLS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= '0; c_q <= '0; rph_q <= '0; cph_q <= '0;
      orow_q <= '0; ocol_q <= '0; slot_q <= '0;
    end else if (cfg_restart) begin
      r_q <= '0; c_q <= '0; rph_q <= '0; cph_q <= '0;
      orow_q <= '0; ocol_q <= '0; slot_q <= '0;
    end else if (step) begin
      if (!col_end) begin
        c_q <= c_q + PW'(1);
        if (c_q + PW'(1) >= pwx) begin
          cph_q <= (cph_q + PW'(1) == scx) ? '0 : cph_q + PW'(1);
        end
        if (col_hit) begin
          ocol_q <= ocol_q + PW'(1);
        end
      end else begin
        c_q    <= '0;
        cph_q  <= '0;
        ocol_q <= '0;
        if (row_end) begin
          r_q <= '0; rph_q <= '0; orow_q <= '0; slot_q <= '0;
        end else begin
          r_q <= r_q + PW'(1);
          if (r_q + PW'(1) >= phx) begin
            rph_q <= (rph_q + PW'(1) == srx) ? '0 : rph_q + PW'(1);
          end
          if (row_hit) begin
            orow_q <= orow_q + PW'(1);
          end
          if (r_q >= pr) begin
            slot_q <= slot_inc;
          end
        end
      end
    end
  end

  // Window scan iterators
  logic [PW-1:0] rb_q, cb_q;
  logic [KW-1:0] ki_q, kj_q;
  logic [SW-1:0] ss_q;
  logic [PW-1:0] res_row_q, res_col_q;
  logic          res_last_q;
  logic [1:0]    res_st_q;

  logic [TW-1:0] base_tmp;
  logic [SW-1:0] base_slot;
  always_comb begin
    base_tmp = TW'(slot_q) + TW'(MAX_POOL) - TW'(ph) + TW'(1);
    if (base_tmp >= TW'(MAX_POOL)) base_tmp = base_tmp - TW'(MAX_POOL);
    base_slot = SW'(base_tmp);
  end

  logic [SW-1:0] ss_inc;
  assign ss_inc = ((SW+1)'(ss_q) + (SW+1)'(1) == (SW+1)'(MAX_POOL)) ? '0 : ss_q + SW'(1);

  logic [PW-1:0] scan_row, scan_col;
  logic          scan_real;
  assign scan_row  = rb_q + PW'(ki_q);
  assign scan_col  = cb_q + PW'(kj_q);
  assign scan_real = (scan_row >= pr) && (scan_row < pr + rows)
                  && (scan_col >= pc) && (scan_col < pc + cols);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rb_q       <= r_q + PW'(1) - phx;
      cb_q       <= c_q + PW'(1) - pwx;
      ki_q       <= '0;
      kj_q       <= '0;
      ss_q       <= base_slot;
      res_row_q  <= orow_q;
      res_col_q  <= ocol_q;
      res_last_q <= last_win;
      res_st_q   <= zero_stride ? ST_ZERO_STRIDE : (kernel_big ? ST_KERNEL_BIG : ST_OK);
    end else if (cmd_i.scan) begin
      if (kj_q + KW'(1) == pw) begin
        kj_q <= '0;
        ki_q <= ki_q + KW'(1);
        ss_q <= ss_inc;
      end else begin
        kj_q <= kj_q + KW'(1);
      end
    end
  end

  // Line store: written on real positions, read once per scan step at real positions
  logic signed [SAMPLE_BITS-1:0] mem [Depth];
  logic signed [SAMPLE_BITS-1:0] rd_data_q;
  logic                          rd_valid_q;
  logic [AW-1:0] waddr, raddr;

  assign waddr = AW'(slot_q) * AW'(MAX_COLS) + AW'(c_q - pc);
  assign raddr = AW'(ss_q) * AW'(MAX_COLS) + AW'(scan_col - pc);

  always_ff @(posedge clk_i) begin
    if (step && real_pos) begin
      mem[waddr] <= is_pad_i ? SampleMin : sample_i;
    end
    if (cmd_i.scan && scan_real) begin
      rd_data_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.scan && scan_real;
    end
  end

  // Running maximum
  logic signed [SAMPLE_BITS-1:0] best_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      best_q <= SampleMin;
    end else if (rd_valid_q && (rd_data_q > best_q)) begin
      best_q <= rd_data_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (res_st_q != ST_OK) begin
        max_value_o     <= '0;
        out_row_o       <= '0;
        out_col_o       <= '0;
        last_of_plane_o <= 1'b0;
      end else begin
        max_value_o     <= best_q;
        out_row_o       <= res_row_q[COORD_W-1:0];
        out_col_o       <= res_col_q[COORD_W-1:0];
        last_of_plane_o <= res_last_q;
      end
      status_o <= res_st_q;
    end
  end

  assign sts_o.err       = zero_stride || kernel_big;
  assign sts_o.win       = row_hit && col_hit;
  assign sts_o.scan_last = (ki_q + KW'(1) == ph) && (kj_q + KW'(1) == pw);
  assign sts_o.out_free  = !out_valid_o || !out_stall_i;

endmodule
`default_nettype wire

>>> hw/rtl/max_pool_2d.sv
// Top level of the 2-D max pooling block: controller plus datapath.
// Depends on mp2d_pkg, mp2d_ctrl and mp2d_datapath.
`default_nettype none
// Streams one channel plane in raster order over the padded plane and emits
// the maximum of each pooling window when its bottom-right sample arrives,
// with the window's output row and column, a flag on the plane's last
// output, and a status code. A request that completes no window leaves the
// input open. A request that completes a window holds off the input while
// its window is read from the line store, which has one read port, one
// element per cycle; then a flush state does the last compare and an emit
// state loads the output register once it is free. With a zero stride or a
// kernel larger than the padded plane every request returns an error status
// with zeroed fields; the position does not move. The output register lets
// the next request enter while a result waits. Any write to one of the eight
// registers restarts the plane at position zero; writes to other indexes are
// dropped. Write configuration only while idle.
module max_pool_2d #(
  parameter int MAX_POOL    = 8,
  parameter int MAX_COLS    = 256,
  parameter int MAX_ROWS    = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input requests
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]   sample_i,
  input  logic                            is_pad_i,
  // Results
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]   max_value_o,
  output logic [mp2d_pkg::COORD_W-1:0]    out_row_o,
  output logic [mp2d_pkg::COORD_W-1:0]    out_col_o,
  output logic                            last_of_plane_o,
  output logic [1:0]                      status_o,
  // Configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mp2d_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mp2d_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import mp2d_pkg::*;

  mp2d_cmd_t cmd;
  mp2d_sts_t sts;

  // Registers are always writable; the user must issue writes only while idle, the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  mp2d_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mp2d_datapath #(
    .MAX_POOL    (MAX_POOL),
    .MAX_COLS    (MAX_COLS),
    .MAX_ROWS    (MAX_ROWS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .sample_i        (sample_i),
    .is_pad_i        (is_pad_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .max_value_o     (max_value_o),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .last_of_plane_o (last_of_plane_o),
    .status_o        (status_o)
  );

`ifndef SYNTHESIS
  // An error result carries zeroed fields.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |->
      (max_value_o == '0 && out_row_o == '0 && out_col_o == '0 && !last_of_plane_o))
    else $error("error result with nonzero fields");

  // A new result is loaded only while the input side is held off.
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result loaded while input side was open");
`endif

endmodule
`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for max_pool_2d: a scoreboard class predicts every window result.
// Depends on mp2d_pkg and max_pool_2d; needs nothing else.
`timescale 1ns / 1ps

import mp2d_pkg::*;

typedef struct packed {
  logic signed [15:0] value;
  logic [8:0]         row;
  logic [8:0]         col;
  logic               last;
  logic [1:0]         status;
} pool_result_t;

class pool_scoreboard;
  logic [8:0]   regs [8];
  int           store [8][256];
  int unsigned  row_pos;
  int unsigned  col_pos;
  pool_result_t pending [$];
  int           errors;

  function new();
    regs = '{9'd2, 9'd2, 9'd2, 9'd2, 9'd0, 9'd0, 9'd256, 9'd256};
    row_pos = 0;
    col_pos = 0;
    errors = 0;
  endfunction

  static function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function void write_reg(int idx, logic [8:0] data);
    logic [8:0] mask [8];
    mask = '{9'd15, 9'd15, 9'd15, 9'd15, 9'd7, 9'd7, 9'd511, 9'd511};
    if (idx >= 8) return;
    regs[idx] = data & mask[idx];
    row_pos = 0;
    col_pos = 0;
  endfunction

  // Advance the plane position and queue the window maximum, if any.
  function void note_request(logic signed [15:0] smp, logic pad);
    int unsigned ph, pw, sr, sc, pr, pc, rows, cols, prows, pcols, r, c, orow, ocol;
    int best;
    pool_result_t res;
    ph = clamp(regs[0], 1, 8);
    pw = clamp(regs[1], 1, 8);
    sr = regs[2];
    sc = regs[3];
    pr = regs[4];
    pc = regs[5];
    rows = clamp(regs[6], 1, 256);
    cols = clamp(regs[7], 1, 256);
    prows = rows + 2 * pr;
    pcols = cols + 2 * pc;
    r = row_pos;
    c = col_pos;
    res = '0;
    if (sr == 0 || sc == 0 || ph > prows || pw > pcols) begin
      res.status = (sr == 0 || sc == 0) ? ST_ZERO_STRIDE : ST_KERNEL_BIG;
      pending.push_back(res);
      return;
    end
    if (r >= pr && r < pr + rows && c >= pc && c < pc + cols)
      store[(r - pr) % 8][c - pc] = pad ? -32768 : int'(smp);
    if (c + 1 < pcols) begin
      col_pos = c + 1;
    end else begin
      col_pos = 0;
      row_pos = (r + 1 < prows) ? r + 1 : 0;
    end
    if (r + 1 < ph || c + 1 < pw) return;
    if ((r + 1 - ph) % sr != 0 || (c + 1 - pw) % sc != 0) return;
    orow = (r + 1 - ph) / sr;
    ocol = (c + 1 - pw) / sc;
    best = -32768;
    for (int unsigned i = r + 1 - ph; i <= r; i++) begin
      if (i < pr || i >= pr + rows) continue;
      for (int unsigned j = c + 1 - pw; j <= c; j++) begin
        if (j < pc || j >= pc + cols) continue;
        if (store[(i - pr) % 8][j - pc] > best) best = store[(i - pr) % 8][j - pc];
      end
    end
    res.value = best[15:0];
    res.row = orow[8:0];
    res.col = ocol[8:0];
    res.last = (orow + 1 == (prows - ph) / sr + 1) && (ocol + 1 == (pcols - pw) / sc + 1);
    res.status = ST_OK;
    pending.push_back(res);
  endfunction

  task report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task check_result(pool_result_t got);
    pool_result_t exp;
    if (pending.size() == 0) begin
      report($sformatf("unexpected result %p", got));
      return;
    end
    exp = pending.pop_front();
    if (got.value !== exp.value)
      report($sformatf("max_value %0d, want %0d", got.value, exp.value));
    if (got.row !== exp.row) report($sformatf("out_row %0d, want %0d", got.row, exp.row));
    if (got.col !== exp.col) report($sformatf("out_col %0d, want %0d", got.col, exp.col));
    if (got.last !== exp.last)
      report($sformatf("last_of_plane %0b, want %0b", got.last, exp.last));
    if (got.status !== exp.status)
      report($sformatf("status %0d, want %0d", got.status, exp.status));
  endtask
endclass

module tb_top;
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic signed [15:0]    sample = '0;
  logic                  is_pad = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [15:0]    max_value;
  logic [8:0]            out_row;
  logic [8:0]            out_col;
  logic                  last_of_plane;
  logic [1:0]            status;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Idle profile: 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly.
  int             idle_mode = 0;
  // Receiver hold-off, counted down by the receiver process.
  int             hold_cycles = 0;
  int             total_items = 0;
  pool_scoreboard sb;

  always #1 clk = ~clk;

  max_pool_2d u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_i       (sample),
    .is_pad_i       (is_pad),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .max_value_o    (max_value),
    .out_row_o      (out_row),
    .out_col_o      (out_col),
    .last_of_plane_o(last_of_plane),
    .status_o       (status),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // Receiver: drive stall at the falling edge; a pending hold-off wins.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      case (idle_mode)
        2:       out_stall <= ($urandom_range(99) < 83);
        3:       out_stall <= ($urandom_range(99) < 12);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // Check every accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{max_value, out_row, out_col, last_of_plane, status});
  end

  // Offer one request, idling first per profile; keep valid high between requests.
  task send_request(logic signed [15:0] smp, logic pad);
    @(negedge clk);
    while ((idle_mode == 1 && $urandom_range(99) < 83) ||
           (idle_mode == 3 && $urandom_range(99) < 12)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample <= smp;
    is_pad <= pad;
    do @(posedge clk); while (in_stall);
    sb.note_request(smp, pad);
    total_items++;
  endtask

  task drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait for all results, then give a window scan time to drain.
  task drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task write_reg(int idx, int data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_data <= data[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data[8:0]);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task apply_setting(int ph, int pw, int sr, int sc, int pr, int pc, int rows, int cols);
    drain();
    write_reg(REG_POOL_H, ph);
    write_reg(REG_POOL_W, pw);
    write_reg(REG_STRIDE_R, sr);
    write_reg(REG_STRIDE_C, sc);
    write_reg(REG_PAD_R, pr);
    write_reg(REG_PAD_C, pc);
    write_reg(REG_ROWS, rows);
    write_reg(REG_COLS, cols);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Stream n requests with random content; optionally pause until all results are in.
  task stream(int n, bit pause_half);
    for (int k = 0; k < n; k++) begin
      if (pause_half && k == n / 2) begin
        drop_valid();
        while (sb.pending.size() != 0) @(posedge clk);
      end
      send_request(rand_sample(), $urandom_range(7) == 0);
    end
    drop_valid();
  endtask

  task random_phase();
    int ph, pw, sr, sc, pr, pc, rows, cols, n;
    ph = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 8);
    pw = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 8);
    sr = ($urandom_range(14) == 0) ? 0 : $urandom_range(1, 8);
    sc = ($urandom_range(14) == 0) ? 0 : $urandom_range(1, 8);
    pr = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(4);
    pc = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(4);
    rows = ($urandom_range(11) == 0) ? $urandom_range(511) : $urandom_range(1, 12);
    cols = ($urandom_range(11) == 0) ? $urandom_range(511) : $urandom_range(1, 12);
    apply_setting(ph, pw, sr, sc, pr, pc, rows, cols);
    if ($urandom_range(5) == 0) write_reg($urandom_range(8, 15), $urandom);
    idle_mode = $urandom_range(3);
    n = (rows + 2 * pr) * (cols + 2 * pc);
    n = n + $urandom_range(n);
    if (n > 120) n = 120;
    if (n < 10) n = 10;
    stream(n, $urandom_range(3) == 0);
  endtask

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic signed [15:0] corner [7];
    sb = new();
    corner = '{16'sh7fff, 16'sh8000, -16'sd1, 16'sd0, 16'sd1, 16'sh0100, -16'sh0100};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: padded 3x3 plane, 2x2 overlapping windows, extreme values and pad flags.
    apply_setting(2, 2, 1, 1, 1, 1, 3, 3);
    for (int k = 0; k < 25; k++)
      send_request(corner[k % 7], (k == 12) || (k == 17));
    drop_valid();
    // Zero stride on each axis, then kernel larger than the padded plane.
    apply_setting(2, 2, 0, 1, 0, 0, 4, 4);
    stream(3, 0);
    apply_setting(2, 2, 1, 0, 0, 0, 4, 4);
    stream(3, 0);
    apply_setting(8, 2, 1, 1, 1, 0, 3, 4);
    stream(3, 0);
    apply_setting(8, 8, 0, 0, 0, 0, 2, 2);
    stream(2, 0);
    // Extremes: largest kernel and stride, saturated plane size.
    apply_setting(8, 8, 8, 8, 4, 4, 8, 8);
    stream(256, 0);
    apply_setting(1, 1, 1, 1, 0, 0, 511, 300);
    stream(40, 0);

    // Long receiver hold-off while the sender offers, pausing halfway for results, to fill the block.
    apply_setting(1, 1, 1, 1, 0, 0, 4, 6);
    hold_cycles = 300;
    stream(48, 1);

    while (total_items < 600) random_phase();

    idle_mode = 0;
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
